// ----- src/affine_texture_span_fog_defines.svh -----
// Assertion macros shared by the span renderer RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef AFFINE_TEXTURE_SPAN_FOG_DEFINES_SVH
`define AFFINE_TEXTURE_SPAN_FOG_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define ATSF_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("atsf: property failed");

// Check that a condition never holds outside reset.
`define ATSF_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("atsf: forbidden condition seen");

`else

`define ATSF_ASSERT(name, prop)
`define ATSF_ASSERT_NEVER(name, cond)

`endif

`endif

// ----- src/atsf_pkg.sv -----
`default_nettype none

package atsf_pkg;

    // Texture edge is 2^TEX_BITS texels
    localparam int TEX_BITS_DEF = 8;

    localparam int PIX_W   = 16;
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int FOG_W   = 3;
    localparam int ADDR_IN_W = 16;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ROW   = 2'd1,
        CMD_EMIT  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel0;
        logic [PIX_W-1:0] pixel1;
        logic [PIX_W-1:0] pixel2;
        logic [PIX_W-1:0] pixel3;
        logic             full_sky;
    } result_t;

    // Per-group shading controls, captured when an emit that is not full-sky is taken
    typedef struct packed {
        logic [1:0]       fog;
        logic [PIX_W-1:0] sky;
        logic             parity;
        logic             half;
    } span_ctl_t;

    // Apply the fog stipple to four fetched texels (in half-res mode, t0 and t2 doubled)
    function automatic result_t shade_group(span_ctl_t ctl,
                                            logic [PIX_W-1:0] t0,
                                            logic [PIX_W-1:0] t1,
                                            logic [PIX_W-1:0] t2,
                                            logic [PIX_W-1:0] t3);
        result_t r;
        logic    fog_any;
        logic    fog_ge2;
        logic    fog_ge3;
        fog_any = (ctl.fog != 2'd0);
        fog_ge2 = ctl.fog[1];
        fog_ge3 = (ctl.fog == 2'd3);
        r.full_sky = 1'b0;
        if (ctl.half)
        begin
            r.pixel0 = t0;
            r.pixel1 = t0;
            r.pixel2 = fog_ge2 ? ctl.sky : t2;
            r.pixel3 = fog_ge2 ? ctl.sky : t2;
        end
        else if (ctl.parity)
        begin
            r.pixel0 = fog_any ? ctl.sky : t0;
            r.pixel1 = fog_ge3 ? ctl.sky : t1;
            r.pixel2 = fog_ge2 ? ctl.sky : t2;
            r.pixel3 = t3;
        end
        else
        begin
            r.pixel0 = fog_ge2 ? ctl.sky : t0;
            r.pixel1 = t1;
            r.pixel2 = fog_any ? ctl.sky : t2;
            r.pixel3 = fog_ge3 ? ctl.sky : t3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/affine_texture_span_fog.sv -----
// Write-texel and start-row transactions are taken one per cycle while no emit is fetching.
// An emit group with fog below 4 issues four texel reads on consecutive cycles through the
// single-port texture memory, and no new transaction is taken until the last read is issued.
// A full-sky emit (fog 4 and up) reads no texels; its result is registered in a pending flag.
// Emits also stall while two results are accepted and not yet delivered.
// Reset clears the accumulators, steps, row settings and half_res, not the texture memory.
`default_nettype none

`include "affine_texture_span_fog_defines.svh"

module affine_texture_span_fog #(
    parameter int TEX_BITS = atsf_pkg::TEX_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_write,
    input  wire logic                                   cfg_data,
    // input channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [1:0]                             cmd,
    input  wire logic [atsf_pkg::ADDR_IN_W-1:0]         texel_addr,
    input  wire logic [atsf_pkg::PIX_W-1:0]             texel_value,
    input  wire logic signed [atsf_pkg::COORD_W-1:0]    u_start,
    input  wire logic signed [atsf_pkg::COORD_W-1:0]    v_start,
    input  wire logic signed [atsf_pkg::COORD_W-1:0]    u_step,
    input  wire logic signed [atsf_pkg::COORD_W-1:0]    v_step,
    input  wire logic [atsf_pkg::FOG_W-1:0]             fog_level,
    input  wire logic [atsf_pkg::PIX_W-1:0]             sky_colour,
    input  wire logic                                   row_odd,
    // output channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [atsf_pkg::PIX_W-1:0]                  pixel0,
    output logic [atsf_pkg::PIX_W-1:0]                  pixel1,
    output logic [atsf_pkg::PIX_W-1:0]                  pixel2,
    output logic [atsf_pkg::PIX_W-1:0]                  pixel3,
    output logic                                        full_sky
);

    localparam int ADDR_W = 2 * TEX_BITS;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PW     = atsf_pkg::PIX_W;
    localparam int CW     = atsf_pkg::COORD_W;
    localparam int FW     = atsf_pkg::FRAC_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic                           half_res_reg;
    logic [CW-1:0]                  u_acc_reg, u_acc_next;
    logic [CW-1:0]                  v_acc_reg, v_acc_next;
    logic [CW-1:0]                  u_inc_reg;
    logic [CW-1:0]                  v_inc_reg;
    logic [atsf_pkg::FOG_W-1:0]     row_fog_reg;
    logic [PW-1:0]                  row_sky_reg;
    logic                           row_par_reg;

    logic                           busy_reg, busy_next;
    logic [1:0]                     fcnt_reg, fcnt_next;
    logic                           rd_valid_reg;
    logic [1:0]                     rd_slot_reg;
    logic [PW-1:0]                  tex0_reg, tex1_reg, tex2_reg;
    atsf_pkg::span_ctl_t            ctl_reg;
    logic                           sky_pend_reg;
    logic [PW-1:0]                  sky_hold_reg;

    atsf_pkg::result_t              out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;
    atsf_pkg::result_t              skid_reg, skid_next;
    logic                           skid_valid_reg, skid_valid_next;
    logic [1:0]                     cred_reg, cred_next;

    logic [PW-1:0]                  tex_mem [0:DEPTH-1];
    logic [PW-1:0]                  mem_q;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    atsf_pkg::cmd_t                 cmd_c;
    logic                           in_fire;
    logic                           acc_write, acc_row, acc_norm, acc_sky, acc_emit;
    logic                           fetch;
    logic [1:0]                     slot;
    logic [ADDR_W-1:0]              raddr, waddr;
    logic                           push;
    atsf_pkg::result_t              push_data;
    atsf_pkg::result_t              sky_group;
    logic                           out_fire;

    assign cmd_c    = atsf_pkg::cmd_t'(cmd);
    assign in_stall = busy_reg || ((cmd_c == atsf_pkg::CMD_EMIT) && (cred_reg == 2'd2));
    assign in_fire  = in_valid && !in_stall;

    assign acc_write = in_fire && (cmd_c == atsf_pkg::CMD_WRITE);
    assign acc_row   = in_fire && (cmd_c == atsf_pkg::CMD_ROW);
    assign acc_emit  = in_fire && (cmd_c == atsf_pkg::CMD_EMIT);
    assign acc_norm  = acc_emit && !row_fog_reg[2];
    assign acc_sky   = acc_emit && row_fog_reg[2];

    // Issue a texel read on the emit cycle and on each busy cycle of the sequencer after it
    assign fetch = acc_norm || busy_reg;
    assign slot  = busy_reg ? fcnt_reg : 2'd0;
    assign raddr = {v_acc_reg[FW +: TEX_BITS], u_acc_reg[FW +: TEX_BITS]};
    assign waddr = ADDR_W'(texel_addr);

    // ---------------------------------------------------------------
    // Texture memory: single port, registered read
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (acc_write)
        begin
            tex_mem[waddr] <= texel_value;
        end
        else if (fetch)
        begin
            mem_q <= tex_mem[raddr];
        end
    end

    // ---------------------------------------------------------------
    // Fetch sequencer and accumulators
    // ---------------------------------------------------------------
    always_comb
    begin
        busy_next  = busy_reg;
        fcnt_next  = fcnt_reg;
        u_acc_next = u_acc_reg;
        v_acc_next = v_acc_reg;
        if (acc_norm)
        begin
            busy_next = 1'b1;
            fcnt_next = 2'd1;
        end
        else if (busy_reg)
        begin
            fcnt_next = fcnt_reg + 2'd1;
            busy_next = (fcnt_reg != 2'd3);
        end
        // load at row start, advance after every texel read
        if (acc_row)
        begin
            u_acc_next = u_start;
            v_acc_next = v_start;
        end
        else if (fetch)
        begin
            u_acc_next = u_acc_reg + u_inc_reg;
            v_acc_next = v_acc_reg + v_inc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_res_reg <= 1'b0;
            u_acc_reg    <= '0;
            v_acc_reg    <= '0;
            u_inc_reg    <= '0;
            v_inc_reg    <= '0;
            row_fog_reg  <= '0;
            row_sky_reg  <= '0;
            row_par_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            fcnt_reg     <= 2'd0;
            rd_valid_reg <= 1'b0;
            rd_slot_reg  <= 2'd0;
            sky_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                half_res_reg <= cfg_data;
            end
            if (acc_row)
            begin
                u_inc_reg   <= u_step;
                v_inc_reg   <= v_step;
                row_fog_reg <= fog_level;
                row_sky_reg <= sky_colour;
                row_par_reg <= row_odd;
            end
            u_acc_reg    <= u_acc_next;
            v_acc_reg    <= v_acc_next;
            busy_reg     <= busy_next;
            fcnt_reg     <= fcnt_next;
            rd_valid_reg <= fetch;
            rd_slot_reg  <= slot;
            sky_pend_reg <= acc_sky;
        end
    end

    // Capture group settings and returning texels
    always_ff @(posedge clk)
    begin
        if (acc_norm)
        begin
            ctl_reg.fog    <= row_fog_reg[1:0];
            ctl_reg.sky    <= row_sky_reg;
            ctl_reg.parity <= row_par_reg;
            ctl_reg.half   <= half_res_reg;
        end
        if (acc_sky)
        begin
            sky_hold_reg <= row_sky_reg;
        end
        if (rd_valid_reg)
        begin
            case (rd_slot_reg)
                2'd0:    tex0_reg <= mem_q;
                2'd1:    tex1_reg <= mem_q;
                2'd2:    tex2_reg <= mem_q;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result assembly
    // ---------------------------------------------------------------
    always_comb
    begin
        sky_group.pixel0   = sky_hold_reg;
        sky_group.pixel1   = sky_hold_reg;
        sky_group.pixel2   = sky_hold_reg;
        sky_group.pixel3   = sky_hold_reg;
        sky_group.full_sky = 1'b1;
    end

    assign push      = sky_pend_reg || (rd_valid_reg && (rd_slot_reg == 2'd3));
    assign push_data = sky_pend_reg ? sky_group
                     : atsf_pkg::shade_group(ctl_reg, tex0_reg, tex1_reg, tex2_reg, mem_q);

    // ---------------------------------------------------------------
    // Output register with skid entry
    // ---------------------------------------------------------------
    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
        // count emits taken and not yet delivered
        cred_next = cred_reg;
        if (acc_emit && !out_fire)
        begin
            cred_next = cred_reg + 2'd1;
        end
        else if (!acc_emit && out_fire)
        begin
            cred_next = cred_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            cred_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            cred_reg       <= cred_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel0    = out_reg.pixel0;
    assign pixel1    = out_reg.pixel1;
    assign pixel2    = out_reg.pixel2;
    assign pixel3    = out_reg.pixel3;
    assign full_sky  = out_reg.full_sky;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ATSF_ASSERT(a_norm_completes, acc_norm |-> ##4 push)
    `ATSF_ASSERT(a_sky_completes, acc_sky |=> push)
    `ATSF_ASSERT(a_no_accept_busy, busy_reg |-> !in_fire)
    `ATSF_ASSERT_NEVER(a_no_overflow, push && skid_valid_reg && !out_fire)
    `ATSF_ASSERT_NEVER(a_credit_range, cred_reg == 2'd3)

endmodule

`default_nettype wire

// ----- test/tb_affine_texture_span_fog.sv -----
`default_nettype none

module tb_affine_texture_span_fog;

    localparam int PIX_W = atsf_pkg::PIX_W;
    localparam int COORD_W = atsf_pkg::COORD_W;
    localparam int FRAC_W = atsf_pkg::FRAC_W;
    localparam int FOG_W = atsf_pkg::FOG_W;
    localparam int ADDR_IN_W = atsf_pkg::ADDR_IN_W;
    localparam int TEX_BITS_DEF = atsf_pkg::TEX_BITS_DEF;

    typedef atsf_pkg::result_t result_t;

    // Command code the block drops without a result
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [FOG_W-1:0] FOG_FULL = 3'd4;
    localparam int TEXELS = 2 ** (2 * TEX_BITS_DEF);
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES = 5;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]           cmd;
        logic [ADDR_IN_W-1:0] addr;
        logic [PIX_W-1:0]     value;
        logic [COORD_W-1:0]   u0;
        logic [COORD_W-1:0]   v0;
        logic [COORD_W-1:0]   du;
        logic [COORD_W-1:0]   dv;
        logic [FOG_W-1:0]     fog;
        logic [PIX_W-1:0]     sky;
        logic                 odd;
    } span_txn_t;

    class span_scoreboard;
        logic [PIX_W-1:0]   texture [TEXELS];
        logic [COORD_W-1:0] u_pos;
        logic [COORD_W-1:0] v_pos;
        logic [COORD_W-1:0] u_inc;
        logic [COORD_W-1:0] v_inc;
        logic [FOG_W-1:0]   fog_lvl;
        logic [PIX_W-1:0]   sky_px;
        logic               odd_row;
        logic               half_mode;
        result_t            expected_groups [$];
        int                 errors;
        int                 groups_checked;

        function new();
            u_pos = '0;
            v_pos = '0;
            u_inc = '0;
            v_inc = '0;
            fog_lvl = '0;
            sky_px = '0;
            odd_row = 1'b0;
            half_mode = 1'b0;
            errors = 0;
            groups_checked = 0;
        endfunction

        // Read at the integer parts of both coordinates, then step them
        function logic [PIX_W-1:0] read_texel();
            logic [2*TEX_BITS_DEF-1:0] idx;
            idx = {v_pos[FRAC_W +: TEX_BITS_DEF], u_pos[FRAC_W +: TEX_BITS_DEF]};
            u_pos = u_pos + u_inc;
            v_pos = v_pos + v_inc;
            return texture[idx];
        endfunction

        function void note_transaction(span_txn_t t);
            result_t          g;
            logic [PIX_W-1:0] px [4];
            case (t.cmd)
                atsf_pkg::CMD_WRITE:
                begin
                    texture[t.addr] = t.value;
                end
                atsf_pkg::CMD_ROW:
                begin
                    u_pos = t.u0;
                    v_pos = t.v0;
                    u_inc = t.du;
                    v_inc = t.dv;
                    fog_lvl = t.fog;
                    sky_px = t.sky;
                    odd_row = t.odd;
                end
                atsf_pkg::CMD_EMIT:
                begin
                    g.full_sky = 1'b0;
                    if (fog_lvl >= FOG_FULL)
                    begin
                        // All sky, coordinates hold
                        for (int k = 0; k < 4; k++)
                            px[k] = sky_px;
                        g.full_sky = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                            px[k] = read_texel();
                        if (half_mode)
                        begin
                            // Keep first and third read, double each
                            px[1] = px[0];
                            if (fog_lvl >= 3'd2)
                                px[2] = sky_px;
                            px[3] = px[2];
                        end
                        else if (fog_lvl != 3'd0)
                        begin
                            // Odd rows fog slots 0,2,1 in turn; even rows 2,0,3
                            if (odd_row)
                            begin
                                px[0] = sky_px;
                                if (fog_lvl >= 3'd2) px[2] = sky_px;
                                if (fog_lvl >= 3'd3) px[1] = sky_px;
                            end
                            else
                            begin
                                px[2] = sky_px;
                                if (fog_lvl >= 3'd2) px[0] = sky_px;
                                if (fog_lvl >= 3'd3) px[3] = sky_px;
                            end
                        end
                    end
                    g.pixel0 = px[0];
                    g.pixel1 = px[1];
                    g.pixel2 = px[2];
                    g.pixel3 = px[3];
                    expected_groups.push_back(g);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [PIX_W-1:0] want,
                                    logic [PIX_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_group(result_t got);
            result_t want;
            if (expected_groups.size() == 0)
            begin
                $error("pixel group %h arrived with none expected", got);
                errors++;
                return;
            end
            want = expected_groups.pop_front();
            groups_checked++;
            compare_field("pixel0", want.pixel0, got.pixel0);
            compare_field("pixel1", want.pixel1, got.pixel1);
            compare_field("pixel2", want.pixel2, got.pixel2);
            compare_field("pixel3", want.pixel3, got.pixel3);
            compare_field("full_sky", PIX_W'(want.full_sky), PIX_W'(got.full_sky));
        endfunction

        function int outstanding();
            return expected_groups.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic                 cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           cmd;
    logic [ADDR_IN_W-1:0] texel_addr;
    logic [PIX_W-1:0]     texel_value;
    logic [COORD_W-1:0]   u_start;
    logic [COORD_W-1:0]   v_start;
    logic [COORD_W-1:0]   u_step;
    logic [COORD_W-1:0]   v_step;
    logic [FOG_W-1:0]     fog_level;
    logic [PIX_W-1:0]     sky_colour;
    logic                 row_odd;
    logic                 out_valid;
    logic                 out_stall;
    logic [PIX_W-1:0]     pixel0;
    logic [PIX_W-1:0]     pixel1;
    logic [PIX_W-1:0]     pixel2;
    logic [PIX_W-1:0]     pixel3;
    logic                 full_sky;

    span_scoreboard sb = new();

    // Stimulus-side view of the row, used to keep every read on a written texel
    logic [COORD_W-1:0] plan_u;
    logic [COORD_W-1:0] plan_v;
    logic [COORD_W-1:0] plan_du;
    logic [COORD_W-1:0] plan_dv;
    logic [FOG_W-1:0]   plan_fog;
    bit                 texel_known [TEXELS];
    int                 items_sent;
    bit                 no_gaps;
    bit                 hold_req;

    affine_texture_span_fog i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $error("run did not finish in time");
        $display("tb_affine_texture_span_fog: FAIL");
        $finish;
    end

    // Note every accepted input transaction
    always @(posedge clk)
    begin
        span_txn_t seen;
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
        begin
            seen.cmd = cmd;
            seen.addr = texel_addr;
            seen.value = texel_value;
            seen.u0 = u_start;
            seen.v0 = v_start;
            seen.du = u_step;
            seen.dv = v_step;
            seen.fog = fog_level;
            seen.sky = sky_colour;
            seen.odd = row_odd;
            sb.note_transaction(seen);
        end
    end

    // Check every accepted pixel group
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_group({pixel0, pixel1, pixel2, pixel3, full_sky});
    end

    // Stall the output: free runs, short and longer stall bursts, long holds on request
    initial
    begin
        int  n;
        int  r;
        bit  s;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                s = 1'b1;
                n = HOLD_CYCLES;
            end
            else
            begin
                r = $urandom_range(0, 99);
                s = (r >= 60);
                if (r < 30)
                    n = $urandom_range(10, 60);
                else if (r < 60)
                    n = $urandom_range(1, 5);
                else if (r < 88)
                    n = $urandom_range(1, 3);
                else
                    n = $urandom_range(8, 40);
            end
            repeat (n)
            begin
                @(posedge clk);
                out_stall <= s;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic span_txn_t random_txn();
        span_txn_t t;
        t.cmd = CMD_NONE;
        t.addr = ADDR_IN_W'($urandom);
        t.value = PIX_W'($urandom);
        t.u0 = $urandom;
        t.v0 = $urandom;
        t.du = $urandom;
        t.dv = $urandom;
        t.fog = FOG_W'($urandom);
        t.sky = PIX_W'($urandom);
        t.odd = 1'($urandom);
        return t;
    endfunction

    // Offer one transaction, hold it until taken, then maybe idle
    task automatic send(input span_txn_t t);
        int gap;
        cmd <= t.cmd;
        texel_addr <= t.addr;
        texel_value <= t.value;
        u_start <= t.u0;
        v_start <= t.v0;
        u_step <= t.du;
        v_step <= t.dv;
        fog_level <= t.fog;
        sky_colour <= t.sky;
        row_odd <= t.odd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        if (t.cmd != CMD_NONE)
            items_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_texel(input logic [ADDR_IN_W-1:0] a, input logic [PIX_W-1:0] v);
        span_txn_t t;
        t = random_txn();
        t.cmd = atsf_pkg::CMD_WRITE;
        t.addr = a;
        t.value = v;
        texel_known[a] = 1'b1;
        send(t);
    endtask

    task automatic start_row(input logic [COORD_W-1:0] u0, input logic [COORD_W-1:0] v0,
                             input logic [COORD_W-1:0] du, input logic [COORD_W-1:0] dv,
                             input logic [FOG_W-1:0] fog, input logic [PIX_W-1:0] sky,
                             input logic odd);
        span_txn_t t;
        t = random_txn();
        t.cmd = atsf_pkg::CMD_ROW;
        t.u0 = u0;
        t.v0 = v0;
        t.du = du;
        t.dv = dv;
        t.fog = fog;
        t.sky = sky;
        t.odd = odd;
        plan_u = u0;
        plan_v = v0;
        plan_du = du;
        plan_dv = dv;
        plan_fog = fog;
        send(t);
    endtask

    // Fill any texel the next group reads that was never written, then emit
    task automatic emit_group();
        span_txn_t            t;
        logic [ADDR_IN_W-1:0] a [4];
        if (plan_fog < FOG_FULL)
        begin
            for (int k = 0; k < 4; k++)
            begin
                a[k] = {plan_v[FRAC_W +: TEX_BITS_DEF], plan_u[FRAC_W +: TEX_BITS_DEF]};
                plan_u = plan_u + plan_du;
                plan_v = plan_v + plan_dv;
            end
            for (int k = 0; k < 4; k++)
                if (!texel_known[a[k]])
                    write_texel(a[k], PIX_W'($urandom));
        end
        t = random_txn();
        t.cmd = atsf_pkg::CMD_EMIT;
        send(t);
    endtask

    task automatic random_row();
        logic [COORD_W-1:0] du;
        logic [COORD_W-1:0] dv;
        logic [FOG_W-1:0]   fog;
        case ($urandom_range(0, 3))
            0:
            begin
                du = $urandom;
                dv = $urandom;
            end
            1:
            begin
                du = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                dv = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            end
            2:
            begin
                du = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
                dv = '0;
            end
            default:
            begin
                du = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                dv = ~du;
            end
        endcase
        if ($urandom_range(0, 99) < 70)
            fog = FOG_W'($urandom_range(0, 3));
        else
            fog = FOG_W'($urandom_range(4, 7));
        start_row($urandom, $urandom, du, dv, fog, PIX_W'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    // Idle the input and wait for every expected group, then let the block settle
    task automatic drain();
        int n;
        in_valid <= 1'b0;
        n = 0;
        // let the monitor note the transaction taken at this edge first
        @(posedge clk);
        while (sb.outstanding() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_half(input logic v);
        drain();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.half_mode = v;
    endtask

    initial
    begin
        span_txn_t t;
        int        target;
        int        r;
        bit        paused;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data <= 1'b0;
        in_valid <= 1'b0;
        cmd <= atsf_pkg::CMD_WRITE;
        texel_addr <= '0;
        texel_value <= '0;
        u_start <= '0;
        v_start <= '0;
        u_step <= '0;
        v_step <= '0;
        fog_level <= '0;
        sky_colour <= '0;
        row_odd <= 1'b0;
        plan_u = '0;
        plan_v = '0;
        plan_du = '0;
        plan_dv = '0;
        plan_fog = '0;
        items_sent = 0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_half(1'b0);

        // Directed: emit before any row, texture corners, wrap, fog levels 0 to 4 and 7
        write_texel('0, 16'hFFFF);
        emit_group();
        write_texel(16'hFFFF, 16'h0000);
        start_row(32'h00FF_0000, 32'h00FF_0000, 32'h0001_0000, 32'h0, 3'd0, 16'hFFFF, 1'b0);
        emit_group();
        start_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  3'd1, 16'h0000, 1'b1);
        emit_group();
        start_row($urandom & 32'hFFFF, $urandom & 32'hFFFF, 32'h0, 32'h0, 3'd2,
                  PIX_W'($urandom), 1'b0);
        emit_group();
        start_row($urandom & 32'hFFFF, $urandom & 32'hFFFF, 32'h0, 32'h0, 3'd3,
                  PIX_W'($urandom), 1'b1);
        emit_group();
        start_row($urandom & 32'hFFFF, $urandom & 32'hFFFF, 32'h0, 32'h0, 3'd3,
                  PIX_W'($urandom), 1'b0);
        emit_group();
        start_row($urandom, $urandom, 32'h0001_0000, 32'h0001_0000, 3'd4, 16'hFFFF, 1'b1);
        emit_group();
        emit_group();
        start_row($urandom, $urandom, 32'h0, 32'h0, 3'd7, 16'h0000, 1'b0);
        emit_group();
        t = random_txn();
        send(t);
        start_row($urandom & 32'hFFFF, $urandom & 32'hFFFF, 32'h0, 32'h0, 3'd1,
                  PIX_W'($urandom), 1'b0);
        emit_group();

        // Random phases, half_res alternating between them
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
                set_half(1'(p % 2));
            if (p % 2 == 1)
                hold_req = 1'b1;
            target = (p + 1) * PHASE_ITEMS;
            while (items_sent < target)
            begin
                // Pause the sender once mid-run until the output side is empty
                if (p == 2 && !paused && items_sent >= target - PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                no_gaps = ($urandom_range(0, 99) < 25);
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    random_row();
                    repeat ($urandom_range(1, 8)) emit_group();
                end
                else if (r < 85)
                    repeat ($urandom_range(1, 4)) emit_group();
                else if (r < 93)
                    repeat ($urandom_range(1, 3))
                        write_texel(ADDR_IN_W'($urandom), PIX_W'($urandom));
                else
                begin
                    t = random_txn();
                    send(t);
                end
            end
        end

        drain();
        if (sb.outstanding() != 0)
        begin
            $error("%0d pixel groups never arrived", sb.outstanding());
            sb.errors++;
        end
        $display("Covered %0d input transactions and %0d pixel groups in %0d phases,",
                 items_sent, sb.groups_checked, NUM_PHASES);
        $display("both half_res settings, fog levels 0 to 7, long output holds and a pause.");
        if (sb.errors == 0)
            $display("tb_affine_texture_span_fog: PASS");
        else
            $display("tb_affine_texture_span_fog: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/atsf_pkg.sv
src/affine_texture_span_fog.sv
test/tb_affine_texture_span_fog.sv
